### rtl/pmst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared sizes, constants and types of the dense Prim spanning tree block.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam int VERTICES    = 8;
	localparam int WEIGHT_BITS = 16;

	localparam int ENTRIES = VERTICES * VERTICES;
	localparam int VW      = $clog2(VERTICES);
	localparam int CW      = $clog2(VERTICES + 1);
	localparam int AW      = $clog2(ENTRIES);
	localparam int KW      = WEIGHT_BITS + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FPW        = $clog2(FIFO_DEPTH);

	localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

	// one matrix entry on its way from front to back
	typedef struct packed {
		logic [AW-1:0]          addr;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   last;
	} word_t;

	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [KW-1:0]          key_t;
	typedef logic [VW-1:0]          vtx_t;

endpackage : pmst_pkg
`default_nettype wire

### rtl/pmst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_front
// Accepts matrix words, tags each with its row-major address and marks the
// final entry of a matrix.
// ----------------------------------------------------------------------------
module pmst_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [15:0]          weight,
	input  wire logic                 fifo_full,
	output logic                      push,
	output pmst_pkg::word_t           push_word
);

	logic [pmst_pkg::AW-1:0] cnt_q;
	logic                    at_end;

	assign at_end   = (cnt_q == pmst_pkg::AW'(pmst_pkg::ENTRIES - 1));
	assign in_stall = fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		push_word.addr   = cnt_q;
		push_word.weight = pmst_pkg::WEIGHT_BITS'(weight);
		push_word.last   = at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= at_end ? '0 : cnt_q + 1'b1;
		end
	end

endmodule : pmst_front
`default_nettype wire

### rtl/pmst_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_fifo
// Short word queue between the front and the compute back end.
// ----------------------------------------------------------------------------
module pmst_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pmst_pkg::word_t push_word,
	output logic                 full,
	output logic                 valid,
	input  wire logic            pop,
	output pmst_pkg::word_t      pop_word
);

	pmst_pkg::word_t             slot_q [pmst_pkg::FIFO_DEPTH];
	logic [pmst_pkg::FPW-1:0]    wr_q;
	logic [pmst_pkg::FPW-1:0]    rd_q;
	logic [pmst_pkg::FPW:0]      count_q;
	logic                        do_pop;

	assign full     = (count_q == (pmst_pkg::FPW+1)'(pmst_pkg::FIFO_DEPTH));
	assign valid    = (count_q != '0);
	assign do_pop   = pop && valid;
	assign pop_word = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule : pmst_fifo
`default_nettype wire

### rtl/pmst_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_back
// Stores the matrix, runs dense Prim from vertex 0 with a sequential min
// search and row relax, then emits one tree edge per non-root vertex.
// ----------------------------------------------------------------------------
module pmst_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fifo_valid,
	input  wire pmst_pkg::word_t fifo_word,
	output logic                 fifo_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [2:0]           parent_vertex,
	output logic [2:0]           child_vertex,
	output logic [15:0]          edge_weight,
	output logic                 unreachable,
	output logic                 last
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEARCH,
		ST_RELAX,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} state_t;

	localparam int VW = pmst_pkg::VW;
	localparam int CW = pmst_pkg::CW;
	localparam int AW = pmst_pkg::AW;

	function automatic logic [AW-1:0] addr_of(input pmst_pkg::vtx_t row,
			input pmst_pkg::vtx_t col);
		return AW'(32'(row) * pmst_pkg::VERTICES + 32'(col));
	endfunction

	state_t                     state_q;
	pmst_pkg::weight_t          mem [pmst_pkg::ENTRIES];
	pmst_pkg::weight_t          rdata_q;

	pmst_pkg::key_t             key_q     [pmst_pkg::VERTICES];
	pmst_pkg::vtx_t             parent_q  [pmst_pkg::VERTICES];
	logic [pmst_pkg::VERTICES-1:0] in_tree_q;
	logic [pmst_pkg::VERTICES-1:0] relaxed_q;

	logic [CW-1:0]              idx_q;
	logic [VW-1:0]              round_q;
	pmst_pkg::key_t             best_q;
	pmst_pkg::vtx_t             pick_q;
	logic                       found_q;
	pmst_pkg::vtx_t             v_s1;
	logic                       vld_s1;

	pmst_pkg::vtx_t             sel_v;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic                       take;
	logic                       found_n;
	pmst_pkg::vtx_t             pick_n;
	logic                       out_free;
	logic                       last_round;
	logic                       relax_hit;

	// key/tree state is looked up at one vertex per cycle
	assign sel_v = (state_q == ST_RELAX) ? v_s1 : idx_q[VW-1:0];

	assign fifo_pop   = (state_q == ST_LOAD) && fifo_valid;
	assign out_free   = !out_valid || !out_stall;
	assign last_round = (round_q == VW'(pmst_pkg::VERTICES - 2));

	assign take    = !in_tree_q[sel_v] && (key_q[sel_v] < best_q);
	assign found_n = found_q || take;
	assign pick_n  = take ? sel_v : pick_q;

	assign relax_hit = vld_s1 && (rdata_q != '0) && !in_tree_q[sel_v]
		&& ({1'b0, rdata_q} < key_q[sel_v]);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_of(idx_q[VW-1:0], parent_q[sel_v]);
		unique case (state_q)
			ST_RELAX: begin
				rd_en   = (idx_q != CW'(pmst_pkg::VERTICES));
				rd_addr = addr_of(pick_q, idx_q[VW-1:0]);
			end
			ST_EMIT_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			mem[fifo_word.addr] <= fifo_word.weight;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			out_valid <= 1'b0;
			idx_q     <= '0;
			round_q   <= '0;
			best_q    <= pmst_pkg::KEY_INF;
			pick_q    <= '0;
			found_q   <= 1'b0;
			v_s1      <= '0;
			vld_s1    <= 1'b0;
			in_tree_q <= '0;
			relaxed_q <= '0;
			for (int i = 0; i < pmst_pkg::VERTICES; i++) begin
				key_q[i]    <= (i == 0) ? '0 : pmst_pkg::KEY_INF;
				parent_q[i] <= '0;
			end
		end else begin
			// emission reloads the output register itself
			if (out_valid && !out_stall && (state_q != ST_EMIT_WAIT)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (fifo_pop && fifo_word.last) begin
						for (int i = 0; i < pmst_pkg::VERTICES; i++) begin
							key_q[i]    <= (i == 0) ? '0 : pmst_pkg::KEY_INF;
							parent_q[i] <= '0;
						end
						in_tree_q <= '0;
						relaxed_q <= '0;
						idx_q     <= '0;
						round_q   <= '0;
						best_q    <= pmst_pkg::KEY_INF;
						found_q   <= 1'b0;
						state_q   <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					vld_s1 <= 1'b0;
					if (idx_q == CW'(pmst_pkg::VERTICES - 1)) begin
						idx_q   <= '0;
						best_q  <= pmst_pkg::KEY_INF;
						found_q <= 1'b0;
						if (found_n) begin
							in_tree_q[pick_n] <= 1'b1;
							pick_q  <= pick_n;
							state_q <= ST_RELAX;
						end else if (last_round) begin
							idx_q   <= CW'(1);
							state_q <= ST_EMIT_RD;
						end else begin
							round_q <= round_q + 1'b1;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						if (take) begin
							best_q  <= key_q[sel_v];
							pick_q  <= sel_v;
							found_q <= 1'b1;
						end
					end
				end
				ST_RELAX: begin
					// read issued for column idx, compare done in the next cycle
					vld_s1 <= rd_en;
					v_s1   <= idx_q[VW-1:0];
					if (relax_hit) begin
						key_q[sel_v]     <= {1'b0, rdata_q};
						parent_q[sel_v]  <= pick_q;
						relaxed_q[sel_v] <= 1'b1;
					end
					if (idx_q == CW'(pmst_pkg::VERTICES)) begin
						if (last_round) begin
							idx_q   <= CW'(1);
							state_q <= ST_EMIT_RD;
						end else begin
							idx_q   <= '0;
							round_q <= round_q + 1'b1;
							state_q <= ST_SEARCH;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						parent_vertex <= 3'(parent_q[sel_v]);
						child_vertex  <= 3'(idx_q[VW-1:0]);
						edge_weight   <= 16'(rdata_q);
						unreachable   <= !relaxed_q[sel_v];
						last          <= (idx_q == CW'(pmst_pkg::VERTICES - 1));
						if (idx_q == CW'(pmst_pkg::VERTICES - 1)) begin
							state_q <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule : pmst_back
`default_nettype wire

### rtl/prim_mst_adjacency_matrix_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prim_mst_adjacency_matrix_top
// Dense Prim minimum spanning tree over an adjacency matrix streamed in.
// ----------------------------------------------------------------------------
// Input channel: one 16-bit matrix weight per word, row-major, zero = no edge.
// Output channel: one word per vertex 1..V-1 in ascending order, giving the
// parent, the child, matrix[child][parent], an unreachable flag and last on
// the word for vertex V-1.
// Loading runs at one word per cycle into a four-deep queue unless the queue
// is full; the back end writes one matrix entry per cycle through its memory
// write port while loading and the queue holds words. After the final entry
// the back end runs V-1 rounds, each a min search over the vertices and then
// a relax of the picked vertex's row (no relax in a round that finds nothing).
// Each result then takes a memory read and an output load.
// The queue absorbs up to four words of the next matrix while computing;
// in_stall rises when it fills. A stalled result holds in the output
// register and emission waits for it. Reset empties the queue, clears the
// entry count and the tree state; matrix memory contents are not reset.
// ----------------------------------------------------------------------------
module prim_mst_adjacency_matrix_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] weight,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       parent_vertex,
	output logic [2:0]       child_vertex,
	output logic [15:0]      edge_weight,
	output logic             unreachable,
	output logic             last
);

	logic            push;
	pmst_pkg::word_t push_word;
	logic            fifo_full;
	logic            fifo_valid;
	logic            fifo_pop;
	pmst_pkg::word_t pop_word;

	pmst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.weight    (weight),
		.fifo_full (fifo_full),
		.push      (push),
		.push_word (push_word)
	);

	pmst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (fifo_full),
		.valid     (fifo_valid),
		.pop       (fifo_pop),
		.pop_word  (pop_word)
	);

	pmst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.fifo_valid    (fifo_valid),
		.fifo_word     (pop_word),
		.fifo_pop      (fifo_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.parent_vertex (parent_vertex),
		.child_vertex  (child_vertex),
		.edge_weight   (edge_weight),
		.unreachable   (unreachable),
		.last          (last)
	);

endmodule : prim_mst_adjacency_matrix_top
`default_nettype wire

### rtl/pmst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pmst_checker
// Port-level checks on both channels of the spanning tree block.
// ----------------------------------------------------------------------------
module pmst_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [15:0] weight,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  parent_vertex,
	input wire logic [2:0]  child_vertex,
	input wire logic [15:0] edge_weight,
	input wire logic        unreachable,
	input wire logic        last
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(weight))
		else $error("stalled input word changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parent_vertex)
			&& $stable(child_vertex) && $stable(edge_weight)
			&& $stable(unreachable) && $stable(last))
		else $error("stalled result word changed");

	a_last_child: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> child_vertex == 3'(pmst_pkg::VERTICES - 1))
		else $error("last flag on wrong vertex");

	a_unreach_parent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unreachable |-> parent_vertex == 3'd0)
		else $error("unreachable vertex with nonzero parent");

	a_child_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> child_vertex != 3'd0)
		else $error("result word for root vertex");

endmodule : pmst_checker

bind prim_mst_adjacency_matrix_top pmst_checker u_pmst_checker (.*);
`default_nettype wire
